>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising clock edge outside reset.
`define ASSERT_IMPLY(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Checks a property in the cycle after a condition.
`define ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

// Checks a property that must hold on every edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

`endif

>>> rtl/core/dq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Opcodes, status codes and shared sizes for the double-ended queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dq_pkg;

    localparam int DEPTH_DEF         = 16;
    localparam int ELEMENT_WIDTH_DEF = 32;
    localparam int OPCODE_W          = 3;
    localparam int PAYLOAD_W         = 32;
    localparam int STATUS_W          = 2;
    localparam int RES_DEPTH         = 3;
    localparam int RES_LEVEL_W       = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_CLEAR      = 3'd4
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

endpackage

>>> rtl/core/dq_result_fifo.sv
// ----------------------------------------------------------------------------
// Result buffer
// Three-entry queue that holds finished results until the output side
// takes them, so that the operation pipeline keeps moving under stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dq_result_fifo #(
    parameter int WIDTH = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [WIDTH-1:0]                    push_data,
    input  logic                                pop,
    output logic                                not_empty,
    output logic [WIDTH-1:0]                    head_data,
    output logic [dq_pkg::RES_LEVEL_W-1:0]      level
);

    localparam logic [dq_pkg::RES_LEVEL_W-1:0] LAST = dq_pkg::RES_LEVEL_W'(dq_pkg::RES_DEPTH - 1);

    logic [WIDTH-1:0]                   slot_reg [dq_pkg::RES_DEPTH];
    logic [dq_pkg::RES_LEVEL_W-1:0]     wr_ptr_reg;
    logic [dq_pkg::RES_LEVEL_W-1:0]     wr_ptr_next;
    logic [dq_pkg::RES_LEVEL_W-1:0]     rd_ptr_reg;
    logic [dq_pkg::RES_LEVEL_W-1:0]     rd_ptr_next;
    logic [dq_pkg::RES_LEVEL_W-1:0]     level_reg;
    logic [dq_pkg::RES_LEVEL_W-1:0]     level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = (level_reg != '0);
    assign head_data = slot_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

>>> rtl/core/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Ring-buffer deque of payload words with push and pop at both ends.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Beat fields
//  -------  -------------------  ----------------------------------
//  input    in_valid / in_stall  opcode, payload_in
//  output   out_valid/out_stall  payload_out, status, occupancy
//
//  One beat is accepted per cycle while in_stall is low; its result is
//  registered with the element memory read and then held in the result buffer.
//  The element memory has one write and one read port, and each operation
//  uses at most one of them, so operations follow each other without a bubble.
//  Reset clears the pointers and count; the element memory is left as is.
//  The input stalls only when the three-entry result buffer could overflow.
//
`timescale 1ns / 1ps

`include "assert_macros.svh"

module double_ended_queue #(
    parameter int DEPTH         = dq_pkg::DEPTH_DEF,
    parameter int ELEMENT_WIDTH = dq_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [dq_pkg::OPCODE_W-1:0]      opcode,
    input  logic [dq_pkg::PAYLOAD_W-1:0]     payload_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [dq_pkg::PAYLOAD_W-1:0]     payload_out,
    output logic [dq_pkg::STATUS_W-1:0]      status,
    output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

    localparam int IW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int RES_W = dq_pkg::PAYLOAD_W + dq_pkg::STATUS_W + CW;
    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [dq_pkg::RES_LEVEL_W-1:0] RES_FULL = dq_pkg::RES_LEVEL_W'(dq_pkg::RES_DEPTH);

    logic [ELEMENT_WIDTH-1:0]            mem [DEPTH];
    logic [ELEMENT_WIDTH-1:0]            rdata_reg;

    logic [IW-1:0]                       front_reg;
    logic [IW-1:0]                       front_next;
    logic [IW-1:0]                       back_reg;
    logic [IW-1:0]                       back_next;
    logic [CW-1:0]                       count_reg;
    logic [CW-1:0]                       count_next;

    logic                                m_valid_reg;
    logic                                m_pop_reg;
    logic                                m_pop_next;
    logic [dq_pkg::STATUS_W-1:0]         m_status_reg;
    logic [dq_pkg::STATUS_W-1:0]         m_status_next;
    logic [CW-1:0]                       m_occ_reg;

    logic                                accept;
    logic                                take;
    logic                                mem_we;
    logic [IW-1:0]                       mem_waddr;
    logic                                mem_re;
    logic [IW-1:0]                       mem_raddr;
    logic                                is_full;
    logic                                is_empty;
    logic [IW-1:0]                       front_inc;
    logic [IW-1:0]                       front_dec;
    logic [IW-1:0]                       back_inc;
    logic [IW-1:0]                       back_dec;
    logic [RES_W-1:0]                    res_data;
    logic [RES_W-1:0]                    head_data;
    logic [dq_pkg::RES_LEVEL_W-1:0]      res_level;
    logic [dq_pkg::RES_LEVEL_W:0]        res_pending;
    logic [IW:0]                         back_sum;
    logic [IW:0]                         back_expect;
    logic                                push_op;

    assign res_pending = {1'b0, res_level} + (dq_pkg::RES_LEVEL_W + 1)'(m_valid_reg);
    assign in_stall    = (res_pending >= (dq_pkg::RES_LEVEL_W + 1)'(dq_pkg::RES_DEPTH));
    assign accept      = in_valid && !in_stall;
    assign take        = out_valid && !out_stall;

    assign is_full   = (count_reg == FULL_CNT);
    assign is_empty  = (count_reg == '0);
    assign front_inc = (front_reg == LAST_IDX) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? LAST_IDX : front_reg - 1'b1;
    assign back_inc  = (back_reg == LAST_IDX) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? LAST_IDX : back_reg - 1'b1;

    always_comb
    begin
        front_next    = front_reg;
        back_next     = back_reg;
        count_next    = count_reg;
        mem_we        = 1'b0;
        mem_waddr     = back_reg;
        mem_re        = 1'b0;
        mem_raddr     = front_reg;
        m_pop_next    = 1'b0;
        m_status_next = dq_pkg::ST_DONE;
        if (accept)
        begin
            case (opcode)
                dq_pkg::OP_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        m_status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = front_dec;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::OP_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        m_status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = back_reg;
                        back_next  = back_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                dq_pkg::OP_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        m_status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = front_reg;
                        m_pop_next = 1'b1;
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                dq_pkg::OP_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        m_status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = back_dec;
                        m_pop_next = 1'b1;
                        back_next  = back_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
                dq_pkg::OP_CLEAR:
                begin
                    front_next = '0;
                    back_next  = '0;
                    count_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg   <= '0;
            back_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg   <= front_next;
            back_reg    <= back_next;
            count_reg   <= count_next;
            m_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_pop_reg    <= m_pop_next;
            m_status_reg <= m_status_next;
            m_occ_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= ELEMENT_WIDTH'(payload_in);
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    assign res_data = {
        (m_pop_reg ? dq_pkg::PAYLOAD_W'(rdata_reg) : {dq_pkg::PAYLOAD_W{1'b0}}),
        m_status_reg,
        m_occ_reg
    };

    dq_result_fifo #(
        .WIDTH (RES_W)
    ) u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (m_valid_reg),
        .push_data (res_data),
        .pop       (take),
        .not_empty (out_valid),
        .head_data (head_data),
        .level     (res_level)
    );

    assign payload_out = head_data[RES_W-1 -: dq_pkg::PAYLOAD_W];
    assign status      = head_data[CW +: dq_pkg::STATUS_W];
    assign occupancy   = head_data[CW-1:0];

    assign back_sum    = {1'b0, front_reg} + (IW + 1)'(count_reg);
    assign back_expect = (back_sum >= (IW + 1)'(DEPTH)) ? back_sum - (IW + 1)'(DEPTH) : back_sum;
    assign push_op     = (opcode == dq_pkg::OP_PUSH_FRONT) || (opcode == dq_pkg::OP_PUSH_BACK);

    `ASSERT_ALWAYS(a_count_bound, count_reg <= FULL_CNT, "element count exceeds depth")
    `ASSERT_ALWAYS(a_back_tracks, back_expect == {1'b0, back_reg}, "back pointer out of step")
    `ASSERT_NEXT(a_full_push_holds, accept && is_full && push_op, count_reg == $past(count_reg) && front_reg == $past(front_reg), "full push changed state")
    `ASSERT_IMPLY(a_buffer_room, m_valid_reg, res_level != RES_FULL || take, "result buffer overflow")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives opcode beats into the deque and checks every result beat against a
// shadow deque kept in the bench. The run covers edge cases, randomized
// fill and drain traffic with idle bursts on both channels, a full drain
// pause, and a closing stretch at full rate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam int DEPTH       = dq_pkg::DEPTH_DEF;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int PTR_W       = $clog2(DEPTH);
    localparam int CYCLE_LIMIT = 250000;
    localparam int REPORT_MAX  = 10;

    localparam logic [dq_pkg::OPCODE_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [dq_pkg::OPCODE_W-1:0] OP_UNUSED_LAST  = 3'd7;

    typedef struct packed {
        logic [dq_pkg::PAYLOAD_W-1:0] payload;
        logic [dq_pkg::STATUS_W-1:0]  status;
        logic [OCC_W-1:0]             occupancy;
    } deque_result_t;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_stall;
    logic [dq_pkg::OPCODE_W-1:0]  opcode;
    logic [dq_pkg::PAYLOAD_W-1:0] payload_in;
    logic                         out_valid;
    logic                         out_stall;
    logic [dq_pkg::PAYLOAD_W-1:0] payload_out;
    logic [dq_pkg::STATUS_W-1:0]  status;
    logic [OCC_W-1:0]             occupancy;

    logic [dq_pkg::PAYLOAD_W-1:0] shadow_store [DEPTH];
    logic [PTR_W-1:0]             shadow_front;
    logic [OCC_W-1:0]             shadow_count;

    deque_result_t pending_results [$];
    deque_result_t oldest_result;
    deque_result_t seen_result;

    int  beats_in;
    int  failures;
    int  cycle_count;
    int  stall_left;
    bit  quiet;
    int  push_total;
    int  full_total;
    int  pop_total;
    int  empty_total;
    int  clear_total;
    int  unused_total;

    double_ended_queue #(
        .DEPTH         (DEPTH),
        .ELEMENT_WIDTH (dq_pkg::ELEMENT_WIDTH_DEF)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .payload_in  (payload_in),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .payload_out (payload_out),
        .status      (status),
        .occupancy   (occupancy)
    );

    always #4 clk = ~clk;

    function automatic deque_result_t deque_step(logic [dq_pkg::OPCODE_W-1:0] op,
                                                 logic [dq_pkg::PAYLOAD_W-1:0] word);
        deque_result_t    r;
        logic [PTR_W-1:0] pos;
        r.payload = '0;
        r.status  = dq_pkg::ST_DONE;
        case (op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK:
            begin
                push_total++;
                if (shadow_count >= DEPTH)
                begin
                    r.status = dq_pkg::ST_FULL;
                    full_total++;
                end
                else if (op == dq_pkg::OP_PUSH_FRONT)
                begin
                    shadow_front = (shadow_front == 0) ? PTR_W'(DEPTH - 1) : shadow_front - 1'b1;
                    shadow_store[shadow_front] = word;
                    shadow_count++;
                end
                else
                begin
                    pos = PTR_W'((int'(shadow_front) + int'(shadow_count)) % DEPTH);
                    shadow_store[pos] = word;
                    shadow_count++;
                end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK:
            begin
                pop_total++;
                if (shadow_count == 0)
                begin
                    r.status = dq_pkg::ST_EMPTY;
                    empty_total++;
                end
                else if (op == dq_pkg::OP_POP_FRONT)
                begin
                    r.payload = shadow_store[shadow_front];
                    shadow_front = PTR_W'((int'(shadow_front) + 1) % DEPTH);
                    shadow_count--;
                end
                else
                begin
                    pos = PTR_W'((int'(shadow_front) + int'(shadow_count) - 1) % DEPTH);
                    r.payload = shadow_store[pos];
                    shadow_count--;
                end
            end
            dq_pkg::OP_CLEAR:
            begin
                clear_total++;
                shadow_front = '0;
                shadow_count = '0;
            end
            default:
            begin
                unused_total++;
            end
        endcase
        r.occupancy = shadow_count;
        return r;
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                seen_result = '{payload_out, status, occupancy};
                if (pending_results.size() == 0)
                begin
                    failures++;
                    if (failures <= REPORT_MAX)
                        $display("Unexpected result beat: payload %h status %0d occupancy %0d",
                                 payload_out, status, occupancy);
                end
                else
                begin
                    oldest_result = pending_results.pop_front();
                    if (seen_result !== oldest_result)
                    begin
                        failures++;
                        if (failures <= REPORT_MAX)
                            $display({"Mismatch: expected payload %h status %0d occupancy %0d,",
                                      " got payload %h status %0d occupancy %0d"},
                                     oldest_result.payload, oldest_result.status,
                                     oldest_result.occupancy, payload_out, status, occupancy);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(deque_step(opcode, payload_in));
                beats_in++;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || quiet)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 3) == 0);
            stall_left = $urandom_range(1, 12);
        end
    end

    function automatic logic [dq_pkg::PAYLOAD_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(input logic [dq_pkg::OPCODE_W-1:0] op,
                             input logic [dq_pkg::PAYLOAD_W-1:0] word);
        int target;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        in_valid   = 1'b1;
        opcode     = op;
        payload_in = word;
        target     = beats_in + 1;
        do
            @(negedge clk);
        while (beats_in < target);
    endtask

    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic test_edge_cases();
        send_beat(dq_pkg::OP_PUSH_FRONT, '0);
        send_beat(dq_pkg::OP_PUSH_BACK, '1);
        for (int i = 0; i < DEPTH - 2; i++)
            send_beat(dq_pkg::OP_PUSH_BACK, (i % 2) ? 32'h5555_5555 : 32'hAAAA_AAAA);
        send_beat(dq_pkg::OP_PUSH_FRONT, 32'h1234_5678);
        send_beat(dq_pkg::OP_PUSH_BACK, 32'h8765_4321);
        send_beat(dq_pkg::OP_POP_FRONT, '1);
        send_beat(dq_pkg::OP_POP_BACK, '1);
        send_beat(dq_pkg::OP_CLEAR, '1);
        for (int k = int'(OP_UNUSED_FIRST); k <= int'(OP_UNUSED_LAST); k++)
            send_beat(dq_pkg::OPCODE_W'(k), '1);
        send_beat(dq_pkg::OP_POP_FRONT, '0);
        send_beat(dq_pkg::OP_POP_BACK, '0);
    endtask

    task automatic test_random_traffic(input int count);
        int                          bias;
        int                          phase_left;
        int                          roll;
        int                          push_pct;
        logic [dq_pkg::OPCODE_W-1:0] op;
        bias       = 0;
        phase_left = 0;
        for (int n = 0; n < count; n++)
        begin
            if (phase_left == 0)
            begin
                bias       = $urandom_range(0, 2);
                phase_left = $urandom_range(10, 50);
            end
            phase_left--;
            push_pct = (bias == 0) ? 85 : (bias == 1) ? 12 : 48;
            roll     = $urandom_range(0, 99);
            if (roll < 1)
                op = dq_pkg::OP_CLEAR;
            else if (roll < 3)
                op = dq_pkg::OPCODE_W'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
            else if ($urandom_range(0, 99) < push_pct)
                op = $urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK;
            else
                op = $urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK;
            send_beat(op, random_word());
        end
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 12; i++)
            send_beat($urandom_range(0, 1) ? dq_pkg::OP_PUSH_FRONT : dq_pkg::OP_PUSH_BACK,
                      random_word());
        wait_for_results();
        for (int i = 0; i < 14; i++)
            send_beat($urandom_range(0, 1) ? dq_pkg::OP_POP_FRONT : dq_pkg::OP_POP_BACK,
                      random_word());
    endtask

    task automatic test_full_rate();
        quiet = 1'b1;
        test_random_traffic(250);
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        opcode     = dq_pkg::OP_PUSH_FRONT;
        payload_in = '0;
        out_stall  = 1'b0;
        quiet      = 1'b0;
        shadow_front = '0;
        shadow_count = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_edge_cases();
        test_random_traffic(650);
        test_drain_pause();
        test_random_traffic(650);
        test_full_rate();

        wait_for_results();
        repeat (8) @(negedge clk);

        $display("Covered %0d beats: %0d pushes (%0d refused when full), %0d pops (%0d on empty),",
                 beats_in, push_total, full_total, pop_total, empty_total);
        $display("%0d clears and %0d unused opcodes, with idle bursts on both channels.",
                 clear_total, unused_total);
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
